>>> sv/gvfm_pkg.sv
// ----------------------------------------------------------------------------
// gvfm_pkg
// Shared types for the greedy voxel face mesher: controller commands and
// status, the controller state encoding, register indexes and actions.
// ----------------------------------------------------------------------------
package gvfm_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   // request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_QUAD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_SEEK_RD,
      ST_SEEK_CHK,
      ST_GROWU_RD,
      ST_GROWU_CHK,
      ST_GROWV_RD,
      ST_GROWV_CHK,
      ST_CLEAR,
      ST_EMIT,
      ST_NEXT_SLICE
   } state_type;

   typedef struct packed {
      logic restart;      // reset scan position
      logic load;         // store the input voxel
      logic build_start;  // start a mask build pass
      logic build_rd;     // issue voxel reads for current mask cell
      logic build_wr;     // write mask cell, advance build counter
      logic seek_rd;      // read mask at scan cell
      logic seek_adv;     // advance scan cell
      logic grow_init;    // latch seed cell
      logic growu_rd;     // read mask at cell right of run
      logic growu_adv;    // widen run
      logic growv_start;  // start checking next row
      logic growv_rd;     // read mask in candidate row
      logic growv_col;    // advance column within row
      logic growv_row;    // accept row, increase height
      logic clear_start;
      logic clear_step;   // clear one cell of the rectangle
      logic emit_quad;
      logic emit_done;
      logic next_slice;
      logic mask_built_set;
   } cmd_type;

   typedef struct packed {
      logic build_last;   // build counter at final cell
      logic axes_done;    // all axes scanned
      logic seek_end;     // scan cell beyond plane
      logic cell_nonzero; // mask read data not air
      logic seed_merge;   // seed cell mergeable
      logic u_match;      // cell right of run matches and in range
      logic v_in_range;   // another row exists
      logic v_match;      // candidate row cell matches
      logic v_col_last;   // final column of candidate row
      logic clear_last;
      logic mask_built;
   } stat_type;

endpackage

>>> sv/gvfm_datapath.sv
// ----------------------------------------------------------------------------
// gvfm_datapath
// Voxel store, face mask memory, scan counters and result register.
// ----------------------------------------------------------------------------
module gvfm_datapath
   import gvfm_pkg::*;
#(
   parameter int MAX_DIM = 16,
   parameter int ID_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [4:0]         csr_size_x,
   input  logic [4:0]         csr_size_y,
   input  logic [4:0]         csr_size_z,
   input  logic [ID_BITS-1:0] req_block_id,
   input  logic               req_renderable,
   input  logic               req_occludes,
   input  logic               req_mergeable,
   output logic               res_done,
   output logic [1:0]         res_axis,
   output logic               res_back,
   output logic [ID_BITS-1:0] res_block,
   output logic [4:0]         res_ox,
   output logic [4:0]         res_oy,
   output logic [4:0]         res_oz,
   output logic [4:0]         res_w,
   output logic [4:0]         res_h
);

   localparam int DB = $clog2(MAX_DIM);
   localparam int CB = DB + 1;            // coordinate incl. MAX_DIM
   localparam int VW = ID_BITS + 3;
   localparam int MW = ID_BITS + 2;
   localparam int PB = 3 * DB;
   localparam int MB = 2 * DB;

   // effective sizes, clamped to 1..MAX_DIM
   logic [CB-1:0] sz [3];
   logic [4:0]    raw [3];
   always_comb begin
      raw[0] = csr_size_x;
      raw[1] = csr_size_y;
      raw[2] = csr_size_z;
      for (int a = 0; a < 3; a++) begin
         if (raw[a] == 5'd0) begin
            sz[a] = CB'(1);
         end else if (32'(raw[a]) > MAX_DIM) begin
            sz[a] = CB'(MAX_DIM);
         end else begin
            sz[a] = CB'(raw[a]);
         end
      end
   end

   // voxel store and load position
   logic [VW-1:0] vox_mem [MAX_DIM*MAX_DIM*MAX_DIM];
   logic [CB-1:0] lx_ff, ly_ff, lz_ff;
   logic          lfull_ff;
   logic [VW-1:0] wvox;

   always_comb begin
      wvox = '0;
      if (req_block_id != '0) begin
         wvox = {req_mergeable, req_occludes, req_renderable, req_block_id};
      end
   end

   // place voxel and advance load position through x, y, z
   always_ff @(posedge clock) begin
      if (reset || cmd.restart && !cmd.load) begin
         lx_ff <= '0; ly_ff <= '0; lz_ff <= '0; lfull_ff <= 1'b0;
      end else if (cmd.load && !lfull_ff) begin
         if (lx_ff + 1'b1 < sz[0]) begin
            lx_ff <= lx_ff + 1'b1;
         end else begin
            lx_ff <= '0;
            if (ly_ff + 1'b1 < sz[1]) begin
               ly_ff <= ly_ff + 1'b1;
            end else begin
               ly_ff <= '0;
               if (lz_ff + 1'b1 < sz[2]) lz_ff <= lz_ff + 1'b1;
               else lfull_ff <= 1'b1;
            end
         end
      end
   end

   // scan registers
   logic [1:0]    axis_ff;
   logic [CB:0]   slice_ff;          // signed, -1..MAX_DIM-1
   logic [CB-1:0] ci_ff, cj_ff;      // scan cell
   logic          built_ff;
   logic [CB-1:0] bi_ff, bj_ff;      // build counter
   logic [1:0]    ua, va;
   logic [CB-1:0] su, sv, sa;

   always_comb begin
      ua = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
      va = (ua == 2'd2) ? 2'd0 : ua + 2'd1;
      su = sz[ua];
      sv = sz[va];
      sa = (axis_ff == 2'd3) ? sz[0] : sz[axis_ff];
   end

   // voxel read addressing for the mask build
   logic [CB:0]   cb [3];
   logic [CB:0]   ca [3];
   logic          ob_b, ob_a;
   logic [PB-1:0] ad_b, ad_a;
   logic [VW-1:0] rb_ff, ra_ff;
   logic          ob_b_ff, ob_a_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cb[a] = '0;
         ca[a] = '0;
      end
      cb[ua] = {1'b0, bi_ff};
      cb[va] = {1'b0, bj_ff};
      ca[ua] = {1'b0, bi_ff};
      ca[va] = {1'b0, bj_ff};
      cb[axis_ff] = slice_ff;
      ca[axis_ff] = slice_ff + 1'b1;
      ob_b = slice_ff[CB];
      ob_a = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (cb[a][CB] || cb[a][CB-1:0] >= sz[a]) ob_b = 1'b1;
         if (ca[a][CB] || ca[a][CB-1:0] >= sz[a]) ob_a = 1'b1;
      end
      ad_b = PB'({cb[2][DB-1:0], cb[1][DB-1:0], cb[0][DB-1:0]});
      ad_a = PB'({ca[2][DB-1:0], ca[1][DB-1:0], ca[0][DB-1:0]});
   end

   logic [PB-1:0] ad_l;
   assign ad_l = PB'({lz_ff[DB-1:0], ly_ff[DB-1:0], lx_ff[DB-1:0]});

   // write on load, read two voxels for a build step
   always_ff @(posedge clock) begin
      if (cmd.load && !lfull_ff) vox_mem[ad_l] <= wvox;
      if (cmd.build_rd) begin
         rb_ff   <= vox_mem[ad_b];
         ra_ff   <= vox_mem[ad_a];
         ob_b_ff <= ob_b;
         ob_a_ff <= ob_a;
      end
   end

   // mask cell from neighbours
   logic [VW-1:0] vb, va_v;
   logic [MW-1:0] mcell;
   always_comb begin
      vb   = ob_b_ff ? '0 : rb_ff;
      va_v = ob_a_ff ? '0 : ra_ff;
      mcell = '0;
      if (vb[ID_BITS] && !va_v[ID_BITS+1]) begin
         mcell = {vb[ID_BITS+2], 1'b0, vb[ID_BITS-1:0]};
      end else if (va_v[ID_BITS] && !vb[ID_BITS+1]) begin
         mcell = {va_v[ID_BITS+2], 1'b1, va_v[ID_BITS-1:0]};
      end
   end

   // face mask memory, single write port, one read port
   logic [MW-1:0] mask_mem [MAX_DIM*MAX_DIM];
   logic [MW-1:0] mrd_ff;
   logic [CB-1:0] ri, rj;            // read coordinate
   logic [CB-1:0] gi_ff, gj_ff;      // seed
   logic [CB-1:0] w_ff, h_ff;        // run size
   logic [CB-1:0] col_ff, row_ff;    // grow/clear cursor
   logic [MW-1:0] seed_ff;
   logic [MB-1:0] wa, ra_m;
   logic [MW-1:0] wd;
   logic          we;

   always_comb begin
      ri = ci_ff;
      rj = cj_ff;
      if (cmd.growu_rd) begin
         ri = gi_ff + w_ff;
         rj = gj_ff;
      end else if (cmd.growv_rd) begin
         ri = gi_ff + col_ff;
         rj = gj_ff + h_ff;
      end
      ra_m = MB'({rj[DB-1:0], ri[DB-1:0]});
      we = cmd.build_wr || cmd.clear_step;
      if (cmd.build_wr) begin
         wa = MB'({bj_ff[DB-1:0], bi_ff[DB-1:0]});
         wd = mcell;
      end else begin
         wa = MB'({(gj_ff[DB-1:0] + row_ff[DB-1:0]), (gi_ff[DB-1:0] + col_ff[DB-1:0])});
         wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mask_mem[wa] <= wd;
      mrd_ff <= mask_mem[ra_m];
   end

   // scan position, build counter, grow cursors
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         axis_ff  <= '0;
         slice_ff <= '1;
         ci_ff    <= '0;
         cj_ff    <= '0;
         built_ff <= 1'b0;
         bi_ff    <= '0;
         bj_ff    <= '0;
      end else begin
         if (cmd.build_start) begin
            bi_ff <= '0; bj_ff <= '0; ci_ff <= '0; cj_ff <= '0;
         end
         if (cmd.build_wr) begin
            if (bi_ff + 1'b1 < su) begin
               bi_ff <= bi_ff + 1'b1;
            end else begin
               bi_ff <= '0;
               bj_ff <= bj_ff + 1'b1;
            end
         end
         if (cmd.mask_built_set) built_ff <= 1'b1;
         if (cmd.seek_adv) begin
            if (ci_ff + 1'b1 < su) begin
               ci_ff <= ci_ff + 1'b1;
            end else begin
               ci_ff <= '0;
               cj_ff <= cj_ff + 1'b1;
            end
         end
         if (cmd.emit_quad) begin
            if (gi_ff + w_ff < su) begin
               ci_ff <= gi_ff + w_ff;
            end else begin
               ci_ff <= '0;
               cj_ff <= gj_ff + 1'b1;
            end
         end
         if (cmd.next_slice) begin
            built_ff <= 1'b0;
            ci_ff <= '0; cj_ff <= '0;
            if ($signed(slice_ff + 1'b1) >= $signed({1'b0, sa})) begin
               axis_ff  <= axis_ff + 2'd1;
               slice_ff <= '1;
            end else begin
               slice_ff <= slice_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grow_init) begin
         gi_ff <= ci_ff; gj_ff <= cj_ff; seed_ff <= mrd_ff;
         w_ff <= CB'(1); h_ff <= CB'(1);
      end
      if (cmd.growu_adv) w_ff <= w_ff + 1'b1;
      if (cmd.growv_start) col_ff <= '0;
      if (cmd.growv_col) col_ff <= col_ff + 1'b1;
      if (cmd.growv_row) begin
         h_ff <= h_ff + 1'b1;
         col_ff <= '0;
      end
      if (cmd.clear_start) begin
         col_ff <= '0; row_ff <= '0;
      end
      if (cmd.clear_step) begin
         if (col_ff + 1'b1 < w_ff) begin
            col_ff <= col_ff + 1'b1;
         end else begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end
      end
   end

   // status
   always_comb begin
      stat.build_last   = (bi_ff + 1'b1 >= su) && (bj_ff + 1'b1 >= sv);
      stat.axes_done    = (axis_ff == 2'd3);
      stat.seek_end     = (cj_ff >= sv);
      stat.cell_nonzero = (mrd_ff != '0);
      stat.seed_merge   = seed_ff[MW-1];
      stat.u_match      = (gi_ff + w_ff < su) && (mrd_ff == seed_ff);
      stat.v_in_range   = (gj_ff + h_ff < sv);
      stat.v_match      = (mrd_ff == seed_ff);
      stat.v_col_last   = (col_ff + 1'b1 >= w_ff);
      stat.clear_last   = (col_ff + 1'b1 >= w_ff) && (row_ff + 1'b1 >= h_ff);
      stat.mask_built   = built_ff;
   end

   // result register
   logic [CB:0] org [3];
   always_comb begin
      org[0] = '0; org[1] = '0; org[2] = '0;
      if (axis_ff != 2'd3) begin
         org[axis_ff] = slice_ff + 1'b1;
         org[ua] = {1'b0, gi_ff};
         org[va] = {1'b0, gj_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_quad) begin
         res_done  <= 1'b0;
         res_axis  <= axis_ff;
         res_back  <= seed_ff[ID_BITS];
         res_block <= seed_ff[ID_BITS-1:0];
         res_ox    <= 5'(org[0]);
         res_oy    <= 5'(org[1]);
         res_oz    <= 5'(org[2]);
         res_w     <= 5'(w_ff);
         res_h     <= 5'(h_ff);
      end else if (cmd.emit_done) begin
         res_done  <= 1'b1;
         res_axis  <= '0;
         res_back  <= 1'b0;
         res_block <= '0;
         res_ox    <= '0;
         res_oy    <= '0;
         res_oz    <= '0;
         res_w     <= '0;
         res_h     <= '0;
      end
   end

endmodule

>>> sv/gvfm_control.sv
// ----------------------------------------------------------------------------
// gvfm_control
// Sequencer: voxel load, mask build, seek, greedy grow, clear, slice advance and result handshake.
// ----------------------------------------------------------------------------
module gvfm_control
   import gvfm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_action,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  logic     csr_write,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;

   always_comb begin
      logic acc;
      acc = req_valid && req_ready;
      state_in = state_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      cmd.restart = csr_write;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && req_action == ACT_LOAD) begin
               cmd.load = 1'b1;
               cmd.restart = 1'b1;
            end else if (acc) begin
               state_in = ST_NEXT_SLICE;
               if (stat.axes_done) begin
                  state_in = ST_EMIT;
               end else if (!stat.mask_built) begin
                  cmd.build_start = 1'b1;
                  state_in = ST_BUILD_RD;
               end else begin
                  state_in = ST_SEEK_RD;
               end
            end
         end
         ST_BUILD_RD: begin
            cmd.build_rd = 1'b1;
            state_in = ST_BUILD_WR;
         end
         ST_BUILD_WR: begin
            cmd.build_wr = 1'b1;
            if (stat.build_last) begin
               cmd.mask_built_set = 1'b1;
               state_in = ST_SEEK_RD;
            end else begin
               state_in = ST_BUILD_RD;
            end
         end
         ST_SEEK_RD: begin
            cmd.seek_rd = 1'b1;
            state_in = stat.seek_end ? ST_NEXT_SLICE : ST_SEEK_CHK;
         end
         ST_SEEK_CHK: begin
            if (stat.cell_nonzero) begin
               cmd.grow_init = 1'b1;
               state_in = ST_GROWU_RD;
            end else begin
               cmd.seek_adv = 1'b1;
               state_in = ST_SEEK_RD;
            end
         end
         ST_GROWU_RD: begin
            if (!stat.seed_merge) begin
               cmd.clear_start = 1'b1;
               state_in = ST_CLEAR;
            end else begin
               cmd.growu_rd = 1'b1;
               state_in = ST_GROWU_CHK;
            end
         end
         ST_GROWU_CHK: begin
            if (stat.u_match) begin
               cmd.growu_adv = 1'b1;
               state_in = ST_GROWU_RD;
            end else begin
               cmd.growv_start = 1'b1;
               state_in = ST_GROWV_RD;
            end
         end
         ST_GROWV_RD: begin
            if (!stat.v_in_range) begin
               cmd.clear_start = 1'b1;
               state_in = ST_CLEAR;
            end else begin
               cmd.growv_rd = 1'b1;
               state_in = ST_GROWV_CHK;
            end
         end
         ST_GROWV_CHK: begin
            if (!stat.v_match) begin
               cmd.clear_start = 1'b1;
               state_in = ST_CLEAR;
            end else if (stat.v_col_last) begin
               cmd.growv_row = 1'b1;
               state_in = ST_GROWV_RD;
            end else begin
               cmd.growv_col = 1'b1;
               state_in = ST_GROWV_RD;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               cmd.emit_quad = 1'b1;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            cmd.emit_done = 1'b1;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_NEXT_SLICE: begin
            if (stat.axes_done) begin
               state_in = ST_EMIT;
            end else if (stat.mask_built) begin
               cmd.next_slice = 1'b1;
            end else begin
               cmd.build_start = 1'b1;
               state_in = ST_BUILD_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> sv/greedy_voxel_face_mesher.sv
// Operation: a load stores one voxel; a quad request builds the face mask for a
// slice, scans its cells, grows a rectangle from a seed and clears it, or moves
// on to the next slice.
// Throughput: one item in flight; a request blocks further beats until its
// result beat is taken. Loads can follow back to back.
// Reset: synchronous; scan restarts, sizes 16, voxel store left unwritten.
// ----------------------------------------------------------------------------
// greedy_voxel_face_mesher
// Loads a voxel chunk and emits greedy merged face rectangles on request.
// ----------------------------------------------------------------------------
module greedy_voxel_face_mesher
   import gvfm_pkg::*;
#(
   parameter int MAX_DIM = 16,
   parameter int ID_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [ID_BITS-1:0] req_block_id,
   input  logic               req_renderable,
   input  logic               req_occludes,
   input  logic               req_mergeable,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_done_res,
   output logic [1:0]         rsp_axis_index,
   output logic               rsp_back_face,
   output logic [ID_BITS-1:0] rsp_face_block,
   output logic [4:0]         rsp_origin_x,
   output logic [4:0]         rsp_origin_y,
   output logic [4:0]         rsp_origin_z,
   output logic [4:0]         rsp_quad_width,
   output logic [4:0]         rsp_quad_height,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_data
);

   logic [4:0] sx_ff, sy_ff, sz_ff;

   // hold chunk size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= 5'd16; sy_ff <= 5'd16; sz_ff <= 5'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SIZE_X: sx_ff <= csr_data;
            REG_SIZE_Y: sy_ff <= csr_data;
            REG_SIZE_Z: sz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   cmd_type  cmd;
   stat_type stat;

   gvfm_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action,
      .rsp_valid, .rsp_ready,
      .csr_write(csr_write && csr_index <= REG_SIZE_Z),
      .stat, .cmd
   );

   gvfm_datapath #(.MAX_DIM(MAX_DIM), .ID_BITS(ID_BITS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .csr_size_x(sx_ff), .csr_size_y(sy_ff), .csr_size_z(sz_ff),
      .req_block_id, .req_renderable, .req_occludes, .req_mergeable,
      .res_done(rsp_done_res), .res_axis(rsp_axis_index),
      .res_back(rsp_back_face), .res_block(rsp_face_block),
      .res_ox(rsp_origin_x), .res_oy(rsp_origin_y), .res_oz(rsp_origin_z),
      .res_w(rsp_quad_width), .res_h(rsp_quad_height)
   );

endmodule
